@@ rtl/plsc_pkg.sv @@
// ----------------------------------------------------------------------------
// plsc_pkg
// shared types, character codes and the byte classifier for the pileup
// line strand counter
// ----------------------------------------------------------------------------
package plsc_pkg;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_C   = 8'h43;
	localparam logic [7:0] CH_UP_G   = 8'h47;
	localparam logic [7:0] CH_UP_T   = 8'h54;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_C   = 8'h63;
	localparam logic [7:0] CH_LO_G   = 8'h67;
	localparam logic [7:0] CH_LO_T   = 8'h74;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [2:0] FIELD_POS         = 3'd1;
	localparam logic [2:0] FIELD_BASES       = 3'd4;
	localparam logic [2:0] FIELD_AFTER_BASES = 3'd5;
	localparam logic [2:0] FIELD_LAST        = 3'd7;

	typedef enum logic [4:0] {
		MARK_NONE  = 5'b00001,
		MARK_FWD   = 5'b00010,
		MARK_REV   = 5'b00100,
		MARK_BEGIN = 5'b01000,
		MARK_END   = 5'b10000
	} base_mark_t;

	typedef struct packed {
		logic nl;
		logic tab;
		logic caret;
		logic dollar;
		logic fwd_base;
		logic rev_base;
		logic digit;
	} byte_class_t;

	function automatic byte_class_t classify(input logic [7:0] ch);
		byte_class_t c;
		c.nl       = (ch == CH_NL);
		c.tab      = (ch == CH_TAB);
		c.caret    = (ch == CH_CARET);
		c.dollar   = (ch == CH_DOLLAR);
		c.fwd_base = (ch == CH_UP_A) || (ch == CH_UP_C) || (ch == CH_UP_G) ||
			(ch == CH_UP_T) || (ch == CH_DOT);
		c.rev_base = (ch == CH_LO_A) || (ch == CH_LO_C) || (ch == CH_LO_G) ||
			(ch == CH_LO_T) || (ch == CH_COMMA);
		c.digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
		return c;
	endfunction

endpackage

@@ rtl/plsc_pos_accum.sv @@
// ----------------------------------------------------------------------------
// plsc_pos_accum
// decimal position accumulator with saturation, and the two site positions
// derived from it
// ----------------------------------------------------------------------------
module plsc_pos_accum
	import plsc_pkg::*;
#(
	parameter int POS_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  byte_class_t          cls,
	input  logic                 in_pos_field,
	input  logic [3:0]           digit,
	output logic [POS_WIDTH-1:0] fwd_site,
	output logic [POS_WIDTH-1:0] rev_site
);

	logic [POS_WIDTH-1:0] pos_q;
	logic [POS_WIDTH+3:0] times10;
	logic [POS_WIDTH-1:0] pos_next;

	always_comb begin
		times10 = {1'b0, pos_q, 3'b000} + {3'b000, pos_q, 1'b0} + (POS_WIDTH+4)'(digit);
		if (|times10[POS_WIDTH+3:POS_WIDTH]) begin
			pos_next = '1;
		end else begin
			pos_next = times10[POS_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step) begin
			if (cls.nl) begin
				pos_q <= '0;
			end else if (in_pos_field && cls.digit) begin
				pos_q <= pos_next;
			end
		end
	end

	assign fwd_site = (pos_q == '0) ? '0 : pos_q - POS_WIDTH'(1);
	assign rev_site = (pos_q == '1) ? pos_q : pos_q + POS_WIDTH'(1);

endmodule

@@ rtl/plsc_line_state.sv @@
// ----------------------------------------------------------------------------
// plsc_line_state
// field tracking, base-string marks and the four saturating strand counters
// of the current line
// ----------------------------------------------------------------------------
module plsc_line_state
	import plsc_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  byte_class_t            cls,
	output logic                   in_pos_field,
	output logic [COUNT_WIDTH-1:0] fwd_count,
	output logic [COUNT_WIDTH-1:0] fwd_start_count,
	output logic [COUNT_WIDTH-1:0] rev_count,
	output logic [COUNT_WIDTH-1:0] rev_end_count
);

	logic [2:0]             field_q, field_d;
	base_mark_t             mark_q, mark_d;
	logic                   skip_q, skip_d;
	logic [COUNT_WIDTH-1:0] fwd_q, fwd_d;
	logic [COUNT_WIDTH-1:0] fwd_start_q, fwd_start_d;
	logic [COUNT_WIDTH-1:0] rev_q, rev_d;
	logic [COUNT_WIDTH-1:0] rev_end_q, rev_end_d;

	always_comb begin
		field_d     = field_q;
		mark_d      = mark_q;
		skip_d      = skip_q;
		fwd_d       = fwd_q;
		fwd_start_d = fwd_start_q;
		rev_d       = rev_q;
		rev_end_d   = rev_end_q;
		if (step) begin
			if (cls.nl) begin
				field_d     = '0;
				mark_d      = MARK_NONE;
				skip_d      = 1'b0;
				fwd_d       = '0;
				fwd_start_d = '0;
				rev_d       = '0;
				rev_end_d   = '0;
			end else if (field_q == FIELD_BASES) begin
				if (skip_q) begin
					skip_d = 1'b0;
				end else if (cls.tab) begin
					field_d = FIELD_AFTER_BASES;
				end else if (cls.caret) begin
					skip_d = 1'b1;
					mark_d = MARK_BEGIN;
				end else if (cls.fwd_base) begin
					if (mark_q == MARK_BEGIN && fwd_start_q != '1) begin
						fwd_start_d = fwd_start_q + COUNT_WIDTH'(1);
					end
					if (fwd_q != '1) begin
						fwd_d = fwd_q + COUNT_WIDTH'(1);
					end
					mark_d = MARK_FWD;
				end else if (cls.rev_base) begin
					if (rev_q != '1) begin
						rev_d = rev_q + COUNT_WIDTH'(1);
					end
					mark_d = MARK_REV;
				end else if (cls.dollar) begin
					if (mark_q == MARK_REV && rev_end_q != '1) begin
						rev_end_d = rev_end_q + COUNT_WIDTH'(1);
					end
					mark_d = MARK_END;
				end
			end else if (cls.tab && field_q != FIELD_LAST) begin
				field_d = field_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q     <= '0;
			mark_q      <= MARK_NONE;
			skip_q      <= 1'b0;
			fwd_q       <= '0;
			fwd_start_q <= '0;
			rev_q       <= '0;
			rev_end_q   <= '0;
		end else begin
			field_q     <= field_d;
			mark_q      <= mark_d;
			skip_q      <= skip_d;
			fwd_q       <= fwd_d;
			fwd_start_q <= fwd_start_d;
			rev_q       <= rev_d;
			rev_end_q   <= rev_end_d;
		end
	end

	assign in_pos_field    = (field_q == FIELD_POS);
	assign fwd_count       = fwd_q;
	assign fwd_start_count = fwd_start_q;
	assign rev_count       = rev_q;
	assign rev_end_count   = rev_end_q;

	// newline leaves a clean line
	assert property (@(posedge clk) disable iff (!arst_n)
		step && cls.nl |=> field_q == '0 && !skip_q && fwd_q == '0 && fwd_start_q == '0 &&
			rev_q == '0 && rev_end_q == '0)
		else $error("line state not cleared after newline");

	// a pending skip only exists inside the base string
	assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> field_q == FIELD_BASES && mark_q == MARK_BEGIN)
		else $error("skip pending outside base string");

	// starts are a subset of forward bases, ends a subset of reverse bases
	assert property (@(posedge clk) disable iff (!arst_n)
		fwd_start_q <= fwd_q && rev_end_q <= rev_q)
		else $error("mark counter exceeds base counter");

endmodule

@@ rtl/pileup_line_strand_counter.sv @@
// ----------------------------------------------------------------------------
// pileup_line_strand_counter
// Parses a tab-separated pileup text stream, one byte per transfer, and on
// each newline emits one result: the parsed position minus one (floored at
// zero), the position plus one (saturating), and the saturating counts of
// forward bases, forward bases right after a read-start mark, reverse bases
// and read-end marks after a reverse base. A byte is taken every cycle; the
// only stall is a newline meeting a result that has not yet been taken. The
// newline is held in the input register, and when it advances, the counters
// and the position are copied straight into the result register and the
// result is marked valid.
// ----------------------------------------------------------------------------
module pileup_line_strand_counter
	import plsc_pkg::*;
#(
	parameter int COUNT_WIDTH = 24,
	parameter int POS_WIDTH   = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata, // text_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	// forward_site_pos, reverse_site_pos, forward_reads, forward_starts,
	// reverse_reads, reverse_ends, zero fill
	output logic [((2*POS_WIDTH+4*COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	localparam int OUT_W   = 2*POS_WIDTH + 4*COUNT_WIDTH;
	localparam int TDATA_W = ((OUT_W + 7) / 8) * 8;

	logic                   byte_valid_s1;
	logic [7:0]             byte_s1;
	byte_class_t            cls_s1;
	logic                   adv;
	logic                   emit;
	logic                   in_pos_field;
	logic [POS_WIDTH-1:0]   fwd_site, rev_site;
	logic [COUNT_WIDTH-1:0] fwd_count, fwd_start_count, rev_count, rev_end_count;
	logic                   out_valid_q;
	logic [OUT_W-1:0]       result_q;

	assign cls_s1        = classify(byte_s1);
	assign adv           = byte_valid_s1 && (!cls_s1.nl || !out_valid_q || m_axis_tready);
	assign emit          = adv && cls_s1.nl;
	assign s_axis_tready = !byte_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			byte_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	plsc_line_state #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_line_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv),
		.cls            (cls_s1),
		.in_pos_field   (in_pos_field),
		.fwd_count      (fwd_count),
		.fwd_start_count(fwd_start_count),
		.rev_count      (rev_count),
		.rev_end_count  (rev_end_count)
	);

	plsc_pos_accum #(
		.POS_WIDTH(POS_WIDTH)
	) u_pos_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.cls         (cls_s1),
		.in_pos_field(in_pos_field),
		.digit       (byte_s1[3:0]),
		.fwd_site    (fwd_site),
		.rev_site    (rev_site)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= {rev_end_count, rev_count, fwd_start_count, fwd_count,
				rev_site, fwd_site};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(result_q);

endmodule
